// ===== rtl/ita_pkg.sv =====
// shared types, constants and glyph lookup for the integer to ascii formatter
package ita_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 8;

  localparam logic KIND_DEC = 1'b0;
  localparam logic KIND_HEX = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A_LC  = 8'h61;

  typedef struct packed {
    logic start;
    logic hex;
  } ita_ctl_t;

  typedef struct packed {
    logic               busy;
    logic [DIGIT_W-1:0] digit;
  } ita_stat_t;

  // digit value to lower-case ascii
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] g;
    if (d < DIGIT_W'(10)) begin
      g = CHAR_ZERO + CHAR_W'(d);
    end else begin
      g = CHAR_A_LC + CHAR_W'(d) - CHAR_W'(10);
    end
    return g;
  endfunction

endpackage

// ===== rtl/ita_digit_unit.sv =====
// digit register with a shift-and-add-3 bcd converter, two bits per cycle; hex loads nibbles directly
module ita_digit_unit #(
  parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF,
  localparam int NDIG  = ((VALUE_BITS * 30103) / 100000 + 1 > (VALUE_BITS + 3) / 4) ?
                         (VALUE_BITS * 30103) / 100000 + 1 : (VALUE_BITS + 3) / 4,
  localparam int IDX_W = $clog2(NDIG)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ita_pkg::ita_ctl_t     ctl,
  input  logic [VALUE_BITS-1:0] mag,
  input  logic [IDX_W-1:0]      rd_idx,
  output ita_pkg::ita_stat_t    stat
);
  import ita_pkg::*;

  localparam int PAD_W   = ((VALUE_BITS + 1) / 2) * 2;
  localparam int STEPS   = PAD_W / 2;
  localparam int CNT_W   = $clog2(STEPS + 1);
  localparam int DIGS_W  = NDIG * DIGIT_W;

  logic [DIGIT_W-1:0] digit [NDIG];
  logic [DIGIT_W-1:0] adj0  [NDIG];
  logic [DIGIT_W-1:0] mid   [NDIG];
  logic [DIGIT_W-1:0] adj1  [NDIG];
  logic [DIGIT_W-1:0] nxt   [NDIG];
  logic [PAD_W-1:0]   bin;
  logic [DIGS_W-1:0]  hex_ext;
  logic               busy;
  logic [CNT_W-1:0]   cnt;

  assign hex_ext = DIGS_W'(mag);

  // two dabble steps per cycle, one per incoming bit
  for (genvar g = 0; g < NDIG; g++) begin : g_lane
    assign adj0[g] = (digit[g] >= DIGIT_W'(5)) ? digit[g] + DIGIT_W'(3) : digit[g];
    if (g == 0) begin : g_lo0
      assign mid[g] = {adj0[g][DIGIT_W-2:0], bin[PAD_W-1]};
    end else begin : g_hi0
      assign mid[g] = {adj0[g][DIGIT_W-2:0], adj0[g-1][DIGIT_W-1]};
    end
    assign adj1[g] = (mid[g] >= DIGIT_W'(5)) ? mid[g] + DIGIT_W'(3) : mid[g];
    if (g == 0) begin : g_lo1
      assign nxt[g] = {adj1[g][DIGIT_W-2:0], bin[PAD_W-2]};
    end else begin : g_hi1
      assign nxt[g] = {adj1[g][DIGIT_W-2:0], adj1[g-1][DIGIT_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= !ctl.hex;
      cnt  <= CNT_W'(STEPS);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      bin <= PAD_W'(mag);
      for (int i = 0; i < NDIG; i++) begin
        digit[i] <= ctl.hex ? hex_ext[i*DIGIT_W +: DIGIT_W] : '0;
      end
    end else if (busy) begin
      bin   <= bin << 2;
      digit <= nxt;
    end
  end

  assign stat.busy  = busy;
  assign stat.digit = digit[rd_idx];

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// top level: integer to ascii formatter, signed decimal or lower-case hex
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------
//  in      | request   | in_valid/in_stall   | kind, value
//  out     | result    | out_valid/out_stall | char_code, last
//
// one request at a time; in_stall is high from accept until the last digit
// is loaded into the output register. decimal: the value runs through the bcd
// converter (two bits per cycle), then the digit slots (NDIG) are walked msd
// first, leading zeros skipped, with a '-' sign sent ahead of the digits.
// hex: the nibbles are loaded directly, then the digit slots (NDIG) are
// walked msd first, leading zeros skipped.
// out_stall only holds the output register and freezes the digit walk.
// synchronous reset clears the sequencer and the output valid.
module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [VALUE_BITS-1:0]       value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ita_pkg::CHAR_W-1:0]  char_code,
  output logic                        last
);
  import ita_pkg::*;

  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int IDX_W      = $clog2(NDIG);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]            state;
  logic                  sign_pend;   // '-' still to go out
  logic                  started;     // first significant digit seen
  logic [IDX_W-1:0]      idx;         // digit slot being looked at, msd first

  logic                  in_acc;
  logic                  is_neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  out_free;
  logic                  skip;
  logic                  emit_sign;
  logic                  emit_dig;
  ita_ctl_t              ctl;
  ita_stat_t             stat;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // two's complement magnitude, wraps for the most negative word
  assign is_neg = (kind == KIND_DEC) && value[VALUE_BITS-1];
  assign mag    = is_neg ? (VALUE_BITS'(0) - value) : value;

  assign ctl.start = in_acc;
  assign ctl.hex   = (kind == KIND_HEX);

  ita_digit_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_digit (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .mag    (mag),
    .rd_idx (idx),
    .stat   (stat)
  );

  // output register can take a new character
  assign out_free = !out_valid || !out_stall;

  // leading zeros are dropped, but slot zero always prints
  assign skip      = !started && (stat.digit == '0) && (idx != '0);
  assign emit_sign = (state == S_EMIT) && out_free && sign_pend;
  assign emit_dig  = (state == S_EMIT) && out_free && !sign_pend && !skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sign_pend <= 1'b0;
      started   <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit_sign || emit_dig) begin
        out_valid <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state     <= S_CONV;
            sign_pend <= is_neg;
            started   <= 1'b0;
            idx       <= IDX_W'(NDIG - 1);
          end
        end
        S_CONV: begin
          if (!stat.busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_sign) begin
            sign_pend <= 1'b0;
          end else if (out_free) begin
            if (!skip) begin
              started <= 1'b1;
            end
            idx <= idx - IDX_W'(1);
            if (idx == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // character payload, no reset needed
  always_ff @(posedge clk) begin
    if (emit_sign) begin
      char_code <= CHAR_MINUS;
      last      <= 1'b0;
    end else if (emit_dig) begin
      char_code <= glyph(stat.digit);
      last      <= (idx == '0);
    end
  end

  // a request always starts a conversion
  a_accept_conv : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_CONV))
    else $error("accepted request did not start conversion");

  // no request may slip in while the converter runs
  a_busy_stall : assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> in_stall)
    else $error("converter busy while input open");

  // the sign goes out as '-' and is never the last character
  a_sign_first : assert property (@(posedge clk) disable iff (rst)
    emit_sign |=> (out_valid && (char_code == CHAR_MINUS) && !last))
    else $error("sign character not loaded");

  // the final digit slot closes the request
  a_last_idle : assert property (@(posedge clk) disable iff (rst)
    (emit_dig && (idx == '0)) |=> (last && out_valid && (state == S_IDLE)))
    else $error("final digit did not end the request");

endmodule

// ===== sim/integer_to_ascii_formatter_checker.sv =====
// checker for the integer to ascii formatter: watches both channels, predicts and compares
module integer_to_ascii_formatter_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               kind,
  input  logic [ita_pkg::VALUE_BITS_DEF-1:0] value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [ita_pkg::CHAR_W-1:0]         char_code,
  input  logic                               last,
  output int                                 chars_pending,
  output int                                 error_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_W = ita_pkg::VALUE_BITS_DEF;
  localparam string DIGIT_GLYPHS = "0123456789abcdef";

  typedef struct packed {
    logic [ita_pkg::CHAR_W-1:0] code;
    logic                       last;
  } char_exp_t;

  char_exp_t char_exp_q[$];
  int        mismatches = 0;
  int        pending_r  = 0;

  assign error_count   = mismatches;
  assign chars_pending = pending_r;

  task automatic report_mismatch(input string msg);
    $display("integer_to_ascii_formatter_checker: mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // expected characters of one request, most significant digit first
  function automatic void predict_chars(input logic k, input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0]          mag;
    logic [3:0]                 d;
    logic [ita_pkg::CHAR_W-1:0] digits[$];
    char_exp_t                  c;
    mag = v;
    if (k == ita_pkg::KIND_DEC && v[WORD_W-1]) begin
      c.code = ita_pkg::CHAR_MINUS;
      c.last = 1'b0;
      char_exp_q.push_back(c);
      mag = WORD_W'(0) - v;
    end
    do begin
      if (k == ita_pkg::KIND_HEX) begin
        d   = mag[3:0];
        mag = mag >> 4;
      end else begin
        d   = 4'(mag % 10);
        mag = mag / 10;
      end
      digits.push_front(DIGIT_GLYPHS[d]);
    end while (mag != 0);
    foreach (digits[i]) begin
      c.code = digits[i];
      c.last = (i == digits.size() - 1);
      char_exp_q.push_back(c);
    end
  endfunction

  task automatic check_char(input logic [ita_pkg::CHAR_W-1:0] code,
                            input logic lst);
    char_exp_t e;
    if (char_exp_q.size() == 0) begin
      report_mismatch($sformatf("char 0x%02h last %b with nothing pending", code, lst));
    end else begin
      e = char_exp_q.pop_front();
      if (code !== e.code)
        report_mismatch($sformatf("char_code 0x%02h, want 0x%02h", code, e.code));
      if (lst !== e.last)
        report_mismatch($sformatf("last %b on char 0x%02h, want %b", lst, e.code, e.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      char_exp_q.delete();
    end else begin
      if (out_valid && !out_stall) check_char(char_code, last);
      if (in_valid && !in_stall) predict_chars(kind, value);
    end
    pending_r <= char_exp_q.size();
  end

endmodule

// ===== sim/integer_to_ascii_formatter_tb.sv =====
// testbench top for the integer to ascii formatter: stimulus, output stalls and verdict
module integer_to_ascii_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_W          = ita_pkg::VALUE_BITS_DEF;
  localparam int RANDOM_REQUESTS = 360;
  localparam int NUM_DIRECTED    = 21;
  // receiver hold-off long enough to back the block up into in_stall
  localparam int LONG_HOLD       = 300;
  localparam int HOLD_AT         = 100;
  localparam int PRESS_REQUESTS  = 25;
  localparam int DRAIN_AT        = 250;
  // idle time after the last character has come back, covers any tail
  localparam int SETTLE_CYCLES   = 60;
  localparam int TIMEOUT_NS      = 12_000_000;

  // directed requests: {kind, value}
  localparam logic [WORD_W:0] DIRECTED [NUM_DIRECTED] = '{
    {ita_pkg::KIND_DEC, 32'h0000_0000},  // zero, both kinds
    {ita_pkg::KIND_HEX, 32'h0000_0000},
    {ita_pkg::KIND_DEC, 32'h8000_0000},  // most negative value
    {ita_pkg::KIND_DEC, 32'h7fff_ffff},  // most positive value
    {ita_pkg::KIND_DEC, 32'hffff_ffff},  // minus one
    {ita_pkg::KIND_HEX, 32'hffff_ffff},  // eight hex digits, all letters
    {ita_pkg::KIND_HEX, 32'h8000_0000},
    {ita_pkg::KIND_DEC, 32'h0000_0001},
    {ita_pkg::KIND_HEX, 32'h0000_0001},
    {ita_pkg::KIND_DEC, 32'h0000_0009},  // one/two digit boundaries
    {ita_pkg::KIND_DEC, 32'h0000_000a},
    {ita_pkg::KIND_HEX, 32'h0000_000f},
    {ita_pkg::KIND_HEX, 32'h0000_0010},
    {ita_pkg::KIND_DEC, 32'h3b9a_ca00},  // ten decimal digits
    {ita_pkg::KIND_DEC, 32'h3b9a_c9ff},
    {ita_pkg::KIND_DEC, 32'hc465_3600},  // minus one billion, sign plus ten digits
    {ita_pkg::KIND_DEC, 32'hffff_fff6},
    {ita_pkg::KIND_HEX, 32'hdead_beef},
    {ita_pkg::KIND_HEX, 32'h0abc_def0},  // a leading zero nibble is dropped
    {ita_pkg::KIND_HEX, 32'h1234_5678},
    {ita_pkg::KIND_DEC, 32'h4996_02d2}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              kind;
  logic [WORD_W-1:0] value;
  logic              out_valid;
  logic              out_stall;
  logic [ita_pkg::CHAR_W-1:0] char_code;
  logic              last;

  int chars_pending;
  int error_count;

  // handshake between the request process and the receiver for the long hold
  logic hold_go;
  logic hold_done;

  // run statistics for the summary
  int n_requests = 0;
  int n_dec      = 0;
  int n_neg      = 0;
  int n_hex      = 0;

  // request-side idle shaping: runs of back-to-back requests
  int burst_left = 0;
  int press_left = 0;

  always #6 clk = ~clk;

  integer_to_ascii_formatter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
  );

  integer_to_ascii_formatter_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .char_code     (char_code),
    .last          (last),
    .chars_pending (chars_pending),
    .error_count   (error_count)
  );

  // idle cycles before the next request: mostly none or short, a few long,
  // with occasional stretches of back-to-back requests
  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(15, 40);
      return 0;
    end else if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // random word, biased toward short numbers, signs and digit-count edges
  function automatic logic [WORD_W-1:0] pick_value();
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] p;
    int                n;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2:    v = WORD_W'($urandom_range(0, 20));
      3:    v = $urandom >> $urandom_range(0, WORD_W - 1);
      4: begin
        // around a power of ten or of sixteen
        p = 1;
        n = $urandom_range(0, 9);
        if ($urandom_range(0, 1)) begin
          repeat (n) p = p * 10;
        end else begin
          p = p << (4 * (n % 8));
        end
        v = p + WORD_W'($urandom_range(0, 2)) - 1;
      end
      default: v = {1'b1, {(WORD_W - 1){1'b0}}} ^ WORD_W'($urandom_range(0, 3));
    endcase
    // flip to negative now and then so small negative numbers show up too
    if ($urandom_range(0, 3) == 0) v = WORD_W'(0) - v;
    return v;
  endfunction

  // offer one request after gap idle cycles and wait for it to be taken
  task automatic send_request(input logic k, input logic [WORD_W-1:0] v, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_requests++;
    if (k == ita_pkg::KIND_HEX) begin
      n_hex++;
    end else begin
      n_dec++;
      if (v[WORD_W-1]) n_neg++;
    end
  endtask

  // wait until every expected character has come back
  task automatic wait_drained();
    do @(posedge clk); while (chars_pending != 0);
  endtask

  // receiver: random stall runs, free-flowing stretches, and one long hold
  initial begin
    int run_left;
    int hold_left;
    int r;
    run_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // no stalls for a while
          out_stall <= 1'b0;
          run_left = $urandom_range(50, 150);
        end else if (r < 40) begin
          out_stall <= 1'b1;
          run_left = (r < 34) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end else begin
          out_stall <= 1'b0;
          run_left = $urandom_range(0, 4);
        end
      end
    end
  end

  // request stimulus and verdict
  initial begin
    logic [WORD_W:0] d;
    logic            k;
    int              gap;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    kind     <= ita_pkg::KIND_DEC;
    value    <= '0;
    hold_go  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, extremes, digit-count edges, both kinds
    // (the value port is exactly the word width, so there are no bits above it)
    foreach (DIRECTED[i]) begin
      d = DIRECTED[i];
      send_request(d[WORD_W], d[WORD_W-1:0], next_gap());
    end
    in_valid <= 1'b0;
    wait_drained();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == HOLD_AT) begin
        // receiver stops taking characters while requests keep coming
        hold_go    <= 1'b1;
        press_left = PRESS_REQUESTS;
      end
      if (i == DRAIN_AT) begin
        // sender goes quiet until the block has emptied
        in_valid <= 1'b0;
        wait_drained();
      end
      if (press_left > 0) begin
        press_left--;
        gap = 0;
      end else begin
        gap = next_gap();
      end
      k = ($urandom_range(0, 1) == 1) ? ita_pkg::KIND_HEX : ita_pkg::KIND_DEC;
      send_request(k, pick_value(), gap);
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("integer_to_ascii_formatter_tb: %0d requests, %0d decimal (%0d negative), %0d hex",
             n_requests, n_dec, n_neg, n_hex);
    $display("integer_to_ascii_formatter_tb: %0d-cycle output hold under load, one mid-run drain",
             LONG_HOLD);
    if (error_count == 0) begin
      $display("integer_to_ascii_formatter_tb: done, clean");
    end else begin
      $display("integer_to_ascii_formatter_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("integer_to_ascii_formatter_tb: timeout with %0d chars pending", chars_pending);
    $display("integer_to_ascii_formatter_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ita_pkg.sv
rtl/ita_digit_unit.sv
rtl/integer_to_ascii_formatter.sv
sim/integer_to_ascii_formatter_checker.sv
sim/integer_to_ascii_formatter_tb.sv
